@@ hdl/ctevq_pkg.sv @@
// Shared types, command codes and defaults for the cycle timer event queue.
`default_nettype none
package ctevq_pkg;

    localparam int NUM_TIMERS_DEF = 16;
    localparam int CYCLE_BITS_DEF = 48;

    typedef enum logic [3:0] {
        CMD_ADVANCE  = 4'd0,
        CMD_SCHEDULE = 4'd1,
        CMD_DELAY    = 4'd2,
        CMD_CANCEL   = 4'd3,
        CMD_PAUSE    = 4'd4,
        CMD_RESUME   = 4'd5,
        CMD_FIRE     = 4'd6,
        CMD_RETURN   = 4'd7,
        CMD_QUERY    = 4'd8
    } t_cmd;

    typedef struct packed {
        logic [3:0]  command;
        logic [3:0]  timer_id;
        logic [47:0] value;
    } t_in_beat;

    typedef struct packed {
        logic        scheduled;
        logic        is_paused;
        logic [47:0] delay_left;
        logic        next_due_valid;
        logic [47:0] next_due;
        logic        fired_valid;
        logic [3:0]  fired_timer;
        logic [47:0] fired_when;
    } t_out_beat;

endpackage
`default_nettype wire

@@ hdl/ctevq_time_mem.sv @@
// Slot due-time memory: one write port, one read port, registered read data.
`default_nettype none
module ctevq_time_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int DW    = 48
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

@@ hdl/cycle_timer_event_queue_top.sv @@
// Cycle timer event queue: command sequencer, slot flags, age matrix and head scan.
// From the accepted input beat to the output beat: an update, a scan over the time
//   memory, and an output load that waits while the output register is held.
// No new command is taken until the output beat of the last one is loaded.
// An output beat may wait in its register while the next command is accepted.
// Reset (synchronous, active low) clears the cycle counter, slot flags, in-flight timer.
`default_nettype none
module cycle_timer_event_queue_top
    import ctevq_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF,
    parameter int CYCLE_BITS = CYCLE_BITS_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_beat  i_in,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_beat      o_out
);

    localparam int IW = $clog2(NUM_TIMERS);
    localparam int KW = IW + 1;
    localparam int CW = CYCLE_BITS;
    localparam int VW = (CW < 48) ? CW : 48;
    localparam int XW = ((IW > 4) ? IW : 4) + 1;
    localparam logic [CW-1:0] CYC_MAX = {CW{1'b1}};

    typedef enum logic [1:0] {S_IDLE, S_EXEC, S_SCAN, S_DONE} t_state;

    // Saturating add at the cycle width.
    function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a, input logic [CW-1:0] b);
        logic [CW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CW] ? CYC_MAX : s[CW-1:0];
    endfunction

    // Time left until due, zero when overdue.
    function automatic logic [CW-1:0] left(input logic [CW-1:0] t, input logic [CW-1:0] c);
        return (t > c) ? (t - c) : '0;
    endfunction

    t_state                r_state;
    logic [3:0]            r_cmd;
    logic [IW-1:0]         r_idx;
    logic                  r_idok;
    logic [CW-1:0]         r_val;
    logic [CW-1:0]         r_cyc;
    logic [NUM_TIMERS-1:0] r_present;
    logic [NUM_TIMERS-1:0] r_paused;
    // r_older[i][j]: slot i was inserted before slot j
    logic [NUM_TIMERS-1:0] r_older [NUM_TIMERS];
    logic                  r_ifv;
    logic [IW-1:0]         r_ift;
    logic [CW-1:0]         r_ifw;
    logic                  r_fv;
    logic [IW-1:0]         r_ft;
    logic [CW-1:0]         r_fw;
    logic [KW-1:0]         r_k;
    logic                  r_hv;
    logic [IW-1:0]         r_hid;
    logic [CW-1:0]         r_ht;
    logic                  r_sch;
    logic                  r_pau;
    logic [CW-1:0]         r_rem;
    logic                  r_ov;
    t_out_beat             r_out;

    logic          in_acc;
    logic [XW-1:0] in_idx_x;
    logic [IW-1:0] mem_raddr;
    logic [CW-1:0] mem_rdata;

    // update decisions for the addressed or in-flight slot
    logic          e_place;
    logic [IW-1:0] e_pa;
    logic [CW-1:0] e_pt;
    logic          e_pp;
    logic          e_cancel;
    logic          e_fire;
    logic          e_ret;
    logic [CW-1:0] n_cyc;
    logic          e_pres;
    logic          e_paus;
    logic [CW-1:0] e_floor;

    // scan entry handled this cycle
    logic [IW-1:0] s_j;
    logic [KW-1:0] s_jk;
    logic          s_qual;
    logic          s_better;

    t_out_beat n_out;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign in_idx_x   = XW'(i_in.timer_id);
    assign mem_raddr  = (r_state == S_SCAN) ? r_k[IW-1:0] : in_idx_x[IW-1:0];

    ctevq_time_mem #(
        .DEPTH (NUM_TIMERS),
        .AW    (IW),
        .DW    (CW)
    ) u_time_mem (
        .i_clk   (i_clk),
        .i_we    ((r_state == S_EXEC) && e_place),
        .i_waddr (e_pa),
        .i_wdata (e_pt),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Decide the update once the slot time of the addressed timer is back.
    always_comb begin
        e_place  = 1'b0;
        e_pa     = r_idx;
        e_pt     = r_val;
        e_pp     = 1'b0;
        e_cancel = 1'b0;
        e_fire   = 1'b0;
        e_ret    = 1'b0;
        n_cyc    = r_cyc;
        e_pres   = r_present[r_idx];
        e_paus   = r_paused[r_idx];
        e_floor  = sat_add(r_ifw, CW'(1));
        case (r_cmd)
            CMD_ADVANCE: begin
                n_cyc = sat_add(r_cyc, r_val);
            end
            CMD_SCHEDULE: begin
                e_place = r_idok;
                e_pp    = e_pres && e_paus;
            end
            CMD_DELAY: begin
                e_place = r_idok && (r_val != '0);
                e_pt    = sat_add(r_cyc, r_val);
                e_pp    = e_pres && e_paus;
            end
            CMD_CANCEL: begin
                e_cancel = r_idok && e_pres;
            end
            CMD_PAUSE: begin
                e_place = r_idok && e_pres;
                e_pt    = e_paus ? mem_rdata : left(mem_rdata, r_cyc);
                e_pp    = 1'b1;
            end
            CMD_RESUME: begin
                e_place = r_idok && e_pres;
                e_pt    = e_paus ? sat_add(mem_rdata, r_cyc) : mem_rdata;
            end
            CMD_FIRE: begin
                e_fire = !r_ifv && r_hv && (r_ht <= r_cyc);
            end
            CMD_RETURN: begin
                e_ret   = r_ifv;
                e_pa    = r_ift;
                e_place = r_ifv && (r_val != '0) && !r_present[r_ift];
                e_pt    = (r_val > e_floor) ? r_val : e_floor;
            end
            default: begin
            end
        endcase
    end

    // Scan compare: earliest due active slot, ties to the older insertion.
    always_comb begin
        s_jk     = r_k - KW'(1);
        s_j      = s_jk[IW-1:0];
        s_qual   = r_present[s_j] && !r_paused[s_j];
        s_better = !r_hv || (mem_rdata < r_ht) ||
                   ((mem_rdata == r_ht) && r_older[s_j][r_hid]);
    end

    always_comb begin
        n_out.scheduled       = r_sch;
        n_out.is_paused       = r_pau;
        n_out.delay_left      = 48'(r_rem);
        n_out.next_due_valid  = r_hv;
        n_out.next_due        = r_hv ? 48'(r_ht) : '0;
        n_out.fired_valid     = r_fv;
        n_out.fired_timer     = 4'(r_ft);
        n_out.fired_when      = 48'(r_fw);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cyc     <= '0;
            r_present <= '0;
            r_paused  <= '0;
            r_ifv     <= 1'b0;
            r_ift     <= '0;
            r_ifw     <= '0;
            r_hv      <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            // drop the output beat once taken; the done step reloads it on its own
            if (r_ov && !i_out_stall && (r_state != S_DONE)) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_cmd   <= i_in.command;
                        r_idx   <= in_idx_x[IW-1:0];
                        r_idok  <= (in_idx_x < XW'(NUM_TIMERS));
                        r_val   <= CW'(i_in.value[VW-1:0]);
                        r_fv    <= 1'b0;
                        r_ft    <= '0;
                        r_fw    <= '0;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_cyc <= n_cyc;
                    if (e_place) begin
                        r_present[e_pa] <= 1'b1;
                        r_paused[e_pa]  <= e_pp;
                        // make the placed slot the youngest
                        for (int i = 0; i < NUM_TIMERS; i++) begin
                            for (int j = 0; j < NUM_TIMERS; j++) begin
                                if (IW'(i) == e_pa) begin
                                    r_older[i][j] <= 1'b0;
                                end else if (IW'(j) == e_pa) begin
                                    r_older[i][j] <= 1'b1;
                                end
                            end
                        end
                    end
                    if (e_cancel) begin
                        r_present[r_idx] <= 1'b0;
                        r_paused[r_idx]  <= 1'b0;
                    end
                    if (e_fire) begin
                        r_present[r_hid] <= 1'b0;
                        r_ifv <= 1'b1;
                        r_ift <= r_hid;
                        r_ifw <= r_ht;
                        r_fv  <= 1'b1;
                        r_ft  <= r_hid;
                        r_fw  <= r_ht;
                    end
                    if (e_ret) begin
                        r_ifv <= 1'b0;
                    end
                    r_k     <= '0;
                    r_hv    <= 1'b0;
                    r_sch   <= 1'b0;
                    r_pau   <= 1'b0;
                    r_rem   <= '0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (r_k != '0) begin
                        if (s_qual && s_better) begin
                            r_hv  <= 1'b1;
                            r_hid <= s_j;
                            r_ht  <= mem_rdata;
                        end
                        if (s_j == r_idx && r_idok && r_present[s_j]) begin
                            r_sch <= 1'b1;
                            r_pau <= r_paused[s_j];
                            r_rem <= r_paused[s_j] ? mem_rdata : left(mem_rdata, r_cyc);
                        end
                    end
                    if (r_k == KW'(NUM_TIMERS)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_k <= r_k + KW'(1);
                    end
                end
                S_DONE: begin
                    // hold until the output register is free
                    if (!r_ov || !i_out_stall) begin
                        r_out   <= n_out;
                        r_ov    <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_ov;
    assign o_out       = r_out;

`ifndef ASSERT_OFF
    a_fire_only_on_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ifv) |-> $past(r_cmd) == CMD_FIRE)
        else $error("in-flight timer set by a command other than fire");

    a_fired_leaves_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ifv) |-> !r_present[r_ift])
        else $error("fired timer still holds a slot");

    a_head_is_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_hv) |-> (r_present[r_hid] && !r_paused[r_hid]))
        else $error("cached head is not an active slot");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_DONE))
        else $error("output beat loaded outside the done step");
`endif

endmodule
`default_nettype wire

@@ sim/tb_cycle_timer_event_queue_top.sv @@
// Testbench for the cycle timer event queue: directed table, random commands, scoreboard.
`timescale 1ns / 100ps
`default_nettype none
module tb_cycle_timer_event_queue_top;
    import ctevq_pkg::*;

    localparam int NT = NUM_TIMERS_DEF;
    localparam logic [47:0] CYC_MAX = {48{1'b1}};
    localparam int CYCLE_LIMIT = 600000;
    localparam int N_RANDOM = 1130;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_beat  i_in = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_beat o_out;

    cycle_timer_event_queue_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    always #10 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Timer queue shadow: cycle counter, slot table, ordered queue and
    // the in-flight timer, all kept at the block's widths.
    // ---------------------------------------------------------------
    logic [47:0] now_cycle;
    logic [47:0] slot_due [NT];
    logic        slot_held [NT];
    logic        slot_live [NT];
    int          order_ids [NT];
    int          order_len;
    logic        flight_on;
    int          flight_id;
    logic [47:0] flight_due;

    t_out_beat   due_results [$];
    int          mismatches = 0;
    int          cycles = 0;
    logic        quiet = 1'b0;   // no idling on either side while set

    function automatic logic [47:0] add_clamped(logic [47:0] a, logic [47:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[48] ? CYC_MAX : s[47:0];
    endfunction

    function automatic void unlink(int id);
        int i;
        for (i = 0; i < order_len; i++) begin
            if (order_ids[i] == id) begin
                for (int j = i; j + 1 < order_len; j++) order_ids[j] = order_ids[j + 1];
                order_len--;
                return;
            end
        end
    endfunction

    // Active slots sort by due cycle, ties behind; paused slots head the paused group.
    function automatic void link(int id);
        int pos;
        int o;
        pos = 0;
        if (order_len >= NT) return;
        while (pos < order_len) begin
            o = order_ids[pos];
            if (slot_held[o]) break;
            if (!slot_held[id] && slot_due[o] > slot_due[id]) break;
            pos++;
        end
        for (int j = order_len; j > pos; j--) order_ids[j] = order_ids[j - 1];
        order_ids[pos] = id;
        order_len++;
    endfunction

    function automatic void put_slot(int id, logic [47:0] t, logic held);
        if (slot_live[id]) unlink(id);
        slot_live[id] = 1'b1;
        slot_due[id]  = t;
        slot_held[id] = held;
        link(id);
    endfunction

    function automatic void clear_queue();
        now_cycle = '0;
        order_len = 0;
        flight_on = 1'b0;
        flight_id = 0;
        flight_due = '0;
        for (int i = 0; i < NT; i++) begin
            slot_due[i] = '0;
            slot_held[i] = 1'b0;
            slot_live[i] = 1'b0;
            order_ids[i] = 0;
        end
    endfunction

    function automatic t_out_beat apply_command(t_in_beat b);
        t_out_beat   r;
        int          id;
        int          f;
        logic [47:0] v;
        logic [47:0] t;
        r = '0;
        id = int'(b.timer_id);
        v = b.value;
        case (b.command)
            CMD_ADVANCE:  now_cycle = add_clamped(now_cycle, v);
            CMD_SCHEDULE: put_slot(id, v, slot_live[id] ? slot_held[id] : 1'b0);
            CMD_DELAY: begin
                if (v != 0)
                    put_slot(id, add_clamped(now_cycle, v),
                             slot_live[id] ? slot_held[id] : 1'b0);
            end
            CMD_CANCEL: begin
                if (slot_live[id]) begin
                    unlink(id);
                    slot_live[id] = 1'b0;
                    slot_held[id] = 1'b0;
                end
            end
            CMD_PAUSE: begin
                if (slot_live[id]) begin
                    t = slot_due[id];
                    if (!slot_held[id]) t = (t > now_cycle) ? t - now_cycle : '0;
                    put_slot(id, t, 1'b1);
                end
            end
            CMD_RESUME: begin
                if (slot_live[id]) begin
                    t = slot_due[id];
                    if (slot_held[id]) t = add_clamped(t, now_cycle);
                    put_slot(id, t, 1'b0);
                end
            end
            CMD_FIRE: begin
                if (!flight_on && order_len > 0) begin
                    f = order_ids[0];
                    if (!slot_held[f] && slot_due[f] <= now_cycle) begin
                        unlink(f);
                        slot_live[f] = 1'b0;
                        flight_on = 1'b1;
                        flight_id = f;
                        flight_due = slot_due[f];
                        r.fired_valid = 1'b1;
                        r.fired_timer = 4'(f);
                        r.fired_when = slot_due[f];
                    end
                end
            end
            CMD_RETURN: begin
                if (flight_on) begin
                    flight_on = 1'b0;
                    if (v != 0 && !slot_live[flight_id]) begin
                        t = add_clamped(flight_due, 48'd1);
                        put_slot(flight_id, (v > t) ? v : t, 1'b0);
                    end
                end
            end
            default: ;
        endcase
        if (slot_live[id]) begin
            r.scheduled = 1'b1;
            r.is_paused = slot_held[id];
            if (slot_held[id]) r.delay_left = slot_due[id];
            else r.delay_left = (slot_due[id] > now_cycle) ? slot_due[id] - now_cycle : '0;
        end
        if (order_len > 0 && !slot_held[order_ids[0]]) begin
            r.next_due_valid = 1'b1;
            r.next_due = slot_due[order_ids[0]];
        end
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Command driver: change inputs at the falling edge, hold the beat
    // until the block takes it, then log the expected result beat.
    // ---------------------------------------------------------------
    task automatic send_command(t_in_beat b, logic typed, t_out_beat typed_exp);
        t_out_beat p;
        @(negedge i_clk);
        while (!quiet && $urandom_range(99) < 7) begin
            i_in_valid = 1'b0;
            i_in = t_in_beat'(56'({$urandom, $urandom}));
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in = b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        p = apply_command(b);
        // hand-typed rows stand in for the predictor's value
        due_results.insert(due_results.size(), typed ? typed_exp : p);
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    // Result side: random stall at the falling edge, check at the rising edge.
    always @(negedge i_clk) begin
        i_out_stall = !quiet && ($urandom_range(99) < 7);
    end

    always @(posedge i_clk) begin
        t_out_beat want;
        cycles++;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (due_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %h", o_out);
            end else begin
                want = due_results[0];
                due_results.delete(0);
                if (o_out !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: want %h got %h", want, o_out);
                end
            end
        end
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Directed table: extremes, every command and the named corner cases.
    // ---------------------------------------------------------------
    typedef struct {
        t_cmd        op;
        int          id;
        logic [47:0] val;
        logic        typed;
        t_out_beat   exp;
    } t_row;

    function automatic t_row mk(t_cmd op, int id, logic [47:0] val);
        t_row r;
        r.op = op; r.id = id; r.val = val; r.typed = 1'b0; r.exp = '0;
        return r;
    endfunction

    function automatic t_row mk_zero(t_cmd op, int id, logic [47:0] val);
        t_row r;
        r = mk(op, id, val);
        r.typed = 1'b1;   // fresh block: nothing scheduled, nothing due
        return r;
    endfunction

    t_row rows [$];

    function automatic void add_row(t_row r);
        rows.insert(rows.size(), r);
    endfunction

    function automatic logic [47:0] rand48();
        return {16'($urandom_range(16'hffff)), $urandom};
    endfunction

    // Keep most times near the counter so fires and reorders happen.
    function automatic logic [47:0] pick_value(t_cmd op);
        int k;
        k = $urandom_range(99);
        if (k < 3) return '0;
        if (k < 5) return rand48();
        if (op == CMD_SCHEDULE || op == CMD_RETURN) begin
            if (k < 60) return now_cycle + 48'($urandom_range(40));
            return (now_cycle > 20) ? now_cycle - 48'($urandom_range(20)) : 48'd5;
        end
        if (op == CMD_ADVANCE) return 48'($urandom_range(12));
        return 48'($urandom_range(30));
    endfunction

    function automatic t_cmd pick_op();
        int k;
        k = $urandom_range(99);
        if (k < 12) return CMD_ADVANCE;
        if (k < 26) return CMD_SCHEDULE;
        if (k < 40) return CMD_DELAY;
        if (k < 46) return CMD_CANCEL;
        if (k < 53) return CMD_PAUSE;
        if (k < 60) return CMD_RESUME;
        if (k < 76) return CMD_FIRE;
        if (k < 89) return CMD_RETURN;
        return CMD_QUERY;
    endfunction

    initial begin
        t_in_beat b;
        t_row     r;
        int       settle;
        clear_queue();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        add_row(mk_zero(CMD_QUERY, 0, '0));
        add_row(mk_zero(CMD_FIRE, 3, '0));
        add_row(mk_zero(CMD_RETURN, 3, 48'd7));
        add_row(mk_zero(CMD_CANCEL, 15, '0));
        add_row(mk_zero(CMD_DELAY, 4, '0));
        add_row(mk(CMD_SCHEDULE, 0, CYC_MAX));
        add_row(mk(CMD_SCHEDULE, 15, 48'd5));
        add_row(mk(CMD_SCHEDULE, 7, 48'd5));
        add_row(mk(CMD_DELAY, 2, 48'd3));
        add_row(mk(CMD_PAUSE, 2, '0));
        add_row(mk(CMD_PAUSE, 2, '0));
        add_row(mk(CMD_SCHEDULE, 2, 48'd9));
        add_row(mk(CMD_ADVANCE, 1, 48'd6));
        add_row(mk(CMD_FIRE, 0, '0));
        add_row(mk(CMD_FIRE, 0, '0));
        add_row(mk(CMD_CANCEL, 15, '0));
        add_row(mk(CMD_SCHEDULE, 15, 48'd2));
        add_row(mk(CMD_RETURN, 0, 48'd1));
        add_row(mk(CMD_FIRE, 0, '0));
        add_row(mk(CMD_RETURN, 9, '0));
        add_row(mk(CMD_RESUME, 2, '0));
        add_row(mk(CMD_RESUME, 2, '0));
        add_row(mk(CMD_DELAY, 1, CYC_MAX));
        add_row(mk(t_cmd'(4'd15), 1, CYC_MAX));
        add_row(mk(t_cmd'(4'd9), 0, 48'h5555_5555_5555));

        foreach (rows[i]) begin
            r = rows[i];
            b.command = r.op;
            b.timer_id = 4'(r.id);
            b.value = r.val;
            send_command(b, r.typed, r.exp);
        end

        // Random commands; a quiet stretch in the middle, counter saturation at the end.
        for (int n = 0; n < N_RANDOM; n++) begin
            quiet = (n >= 400 && n < 600);
            b.command = pick_op();
            if ($urandom_range(99) < 3) b.command = 4'($urandom_range(9, 15));
            b.timer_id = 4'($urandom_range(15));
            b.value = pick_value(t_cmd'(b.command));
            if (n == N_RANDOM - 40) begin
                b.command = CMD_ADVANCE;
                b.value = CYC_MAX;
            end
            send_command(b, 1'b0, '0);
        end

        while (due_results.size() != 0) @(posedge i_clk);
        settle = 0;
        while (settle < 4 * (NT + 3)) begin
            @(posedge i_clk);
            settle++;
        end
        if (mismatches == 0 && due_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire

@@ cycle_timer_event_queue_top.f @@
hdl/ctevq_pkg.sv
hdl/ctevq_time_mem.sv
hdl/cycle_timer_event_queue_top.sv
sim/tb_cycle_timer_event_queue_top.sv
